// ----- hdl/kpbm_pkg.sv -----
// Shared types, codes and defaults for the k-mer weight-matrix scanner.
`default_nettype none
package kpbm_pkg;
	localparam int MOTIFS_DEF = 64;
	localparam int MWIDTH_DEF = 32;
	localparam int KMER_DEF   = 16;

	localparam int SCORE_W = 24;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 24'sh800000;
	localparam logic signed [SCORE_W-1:0] THR_RESET = -24'sd256000;
	localparam logic [4:0] KLEN_RESET = 5'd8;

	localparam logic [1:0] CMD_WEIGHT = 2'd0;
	localparam logic [1:0] CMD_WIDTH  = 2'd1;
	localparam logic [1:0] CMD_SCORE  = 2'd2;

	localparam logic [1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_MOTIFS    = 2'd1;
	localparam logic [1:0] CFG_KLEN      = 2'd2;

	// column beat broadcast to every lane
	typedef struct packed {
		logic       vld;
		logic [5:0] col;
		logic [5:0] klen;
	} lane_ctl_t;

	typedef struct packed {
		logic       vld;
		logic [9:0] motif;
	} merge_ctl_t;
endpackage
`default_nettype wire

// ----- hdl/kpbm_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module kpbm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/kpbm_lane.sv -----
// One window lane: accumulates the weights of one offset on one strand.
`default_nettype none
module kpbm_lane #(
	parameter int OFF      = 0,
	parameter int MAX_KMER = 16
) (
	input  wire logic                        clk,
	input  wire kpbm_pkg::lane_ctl_t         ctl,
	input  wire logic [2*MAX_KMER-1:0]       seq,
	input  wire logic [63:0]                 wt,
	output logic                             fin,
	output logic signed [23:0]               sum
);
	import kpbm_pkg::*;

	localparam int KIW = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;

	logic signed [SCORE_W-1:0] acc_q;
	logic [5:0]                idx;
	logic                      inw;
	logic [1:0]                b;
	logic [15:0]               wsel;

	always_comb begin
		idx  = ctl.col - 6'(OFF);
		inw  = ctl.vld && (ctl.col >= 6'(OFF)) && (idx < ctl.klen);
		b    = seq[{idx[KIW-1:0], 1'b0} +: 2];
		wsel = wt[{b, 4'b0000} +: 16];
		sum  = ((idx == 6'd0) ? '0 : acc_q) + {{(SCORE_W-16){wsel[15]}}, wsel};
		fin  = inw && (idx == ctl.klen - 6'd1);
	end

	always_ff @(posedge clk) begin
		if (inw) begin
			acc_q <= sum;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/kpbm_merge.sv -----
// Merge stage: picks the finished window sums and keeps the running best.
`default_nettype none
module kpbm_merge #(
	parameter int LANES = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        clear,
	input  wire kpbm_pkg::merge_ctl_t        mctl,
	input  wire logic [LANES-1:0]            fin_f,
	input  wire logic signed [23:0]          sum_f [LANES],
	input  wire logic [LANES-1:0]            fin_r,
	input  wire logic signed [23:0]          sum_r [LANES],
	input  wire logic signed [23:0]          thr,
	output logic                             found,
	output logic [9:0]                       motif,
	output logic signed [23:0]               score
);
	import kpbm_pkg::*;

	logic [SCORE_W-1:0]        orf, orr;
	logic signed [SCORE_W-1:0] cand;
	logic                      vf, vr, upd;

	// at most one lane per strand finishes in a beat, so an OR selects it
	always_comb begin
		orf = '0;
		orr = '0;
		for (int l = 0; l < LANES; l++) begin
			if (fin_f[l]) orf = orf | sum_f[l];
			if (fin_r[l]) orr = orr | sum_r[l];
		end
		vf = |fin_f;
		vr = |fin_r;
		if (vf && vr) begin
			cand = (signed'(orf) > signed'(orr)) ? signed'(orf) : signed'(orr);
		end else if (vf) begin
			cand = signed'(orf);
		end else begin
			cand = signed'(orr);
		end
		upd = mctl.vld && (vf || vr) && (cand > thr) && (!found || cand > score);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
			motif <= '0;
			score <= SCORE_MIN;
		end else if (clear) begin
			found <= 1'b0;
			motif <= '0;
			score <= SCORE_MIN;
		end else if (upd) begin
			found <= 1'b1;
			motif <= mctl.motif;
			score <= cand;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/kmer_pwm_best_motif.sv -----
// Top level: command decode, weight and width stores, column sequencer, lanes, merge.
//
// Input channel (in_valid/in_stall) takes one command a beat unless in_stall is
// high: weight and width writes complete in the beat accepted and give no result.
// A score beat runs the k-mer and its reverse complement over every motif in
// use; one lane per offset and strand sums weights while the sequencer steps
// through the motif columns, one column a cycle from the weight store.
// Each motif whose width is at least k has its columns walked through the weight
// store; narrower motifs are skipped. in_stall is high while a score beat is in work.
// The result (found, best_motif, best_score) sits in an output register held
// while out_stall is high; the next command is accepted meanwhile, and a
// further score result waits until that register drains.
// Configuration (cfg_valid/cfg_ready) is always ready; write only when idle.
// Reset clears the width table and control state and sets the configuration
// registers to their defaults; the weight store keeps no reset and must be written before use.
`default_nettype none
module kmer_pwm_best_motif #(
	parameter int MAX_MOTIFS      = kpbm_pkg::MOTIFS_DEF,
	parameter int MAX_MOTIF_WIDTH = kpbm_pkg::MWIDTH_DEF,
	parameter int MAX_KMER        = kpbm_pkg::KMER_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         command,
	input  wire logic [5:0]         motif_index,
	input  wire logic [1:0]         base_row,
	input  wire logic [4:0]         column,
	input  wire logic signed [15:0] weight,
	input  wire logic [5:0]         motif_width,
	input  wire logic [31:0]        kmer_bases,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    found,
	output logic [5:0]              best_motif,
	output logic signed [23:0]      best_score,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [23:0]        cfg_data
);
	import kpbm_pkg::*;

	localparam int MW   = (MAX_MOTIFS > 1) ? $clog2(MAX_MOTIFS) : 1;
	localparam int NW   = $clog2(MAX_MOTIFS + 1);
	localparam int CW   = (MAX_MOTIF_WIDTH > 1) ? $clog2(MAX_MOTIF_WIDTH) : 1;
	localparam int WSW  = $clog2(MAX_MOTIF_WIDTH + 1);
	localparam int KLW  = $clog2(MAX_KMER + 1);
	localparam int WDEP = MAX_MOTIFS * MAX_MOTIF_WIDTH;
	localparam int AW   = (WDEP > 1) ? $clog2(WDEP) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WREQ = 3'd1;
	localparam logic [2:0] S_WCHK = 3'd2;
	localparam logic [2:0] S_COLS = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]                state_q;
	logic signed [SCORE_W-1:0] thr_q;
	logic [6:0]                mcount_q;
	logic [4:0]                klen_q;

	logic [KLW-1:0]            k_q, kn;
	logic [NW-1:0]             n_q, nn;
	logic [MW-1:0]             m_q;
	logic [CW-1:0]             c_q, wlast_q;
	logic [2*MAX_KMER-1:0]     fwd_q, rev_q, fb, rb;
	logic [MAX_MOTIFS-1:0]     wv_q;
	logic                      wvr_q;
	logic [WSW-1:0]            wrd, wcur, wsat;
	logic                      acc_in, wr_w, wr_m, sc;
	logic                      last_m;
	logic                      clear;

	lane_ctl_t                 ctl_s1;
	logic [MW-1:0]             motif_s1;
	merge_ctl_t                mctl;
	logic [63:0]               wt;
	logic [AW-1:0]             waddr, raddr;

	logic [MAX_MOTIF_WIDTH-1:0] fin_f, fin_r;
	logic signed [23:0]         sum_f [MAX_MOTIF_WIDTH];
	logic signed [23:0]         sum_r [MAX_MOTIF_WIDTH];
	logic                       mfound;
	logic [9:0]                 mmotif;
	logic signed [23:0]         mscore;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign acc_in    = in_valid && !in_stall;
	assign wr_w = acc_in && (command == CMD_WEIGHT) && (int'(motif_index) < MAX_MOTIFS)
		&& (int'(column) < MAX_MOTIF_WIDTH);
	assign wr_m = acc_in && (command == CMD_WIDTH) && (int'(motif_index) < MAX_MOTIFS);
	assign sc   = acc_in && (command == CMD_SCORE);
	assign clear = sc;
	assign last_m = (int'(m_q) + 1 == int'(n_q));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			mcount_q <= '0;
			klen_q   <= KLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_THRESHOLD: thr_q    <= signed'(cfg_data);
				CFG_MOTIFS:    mcount_q <= cfg_data[6:0];
				CFG_KLEN:      klen_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// k-mer unpack, clamps and reverse complement
	always_comb begin
		int j;
		j = 0;
		if (klen_q == 5'd0) begin
			kn = KLW'(1);
		end else if (int'(klen_q) > MAX_KMER) begin
			kn = KLW'(MAX_KMER);
		end else begin
			kn = KLW'(klen_q);
		end
		nn = (int'(mcount_q) > MAX_MOTIFS) ? NW'(MAX_MOTIFS) : NW'(mcount_q);
		wsat = (int'(motif_width) > MAX_MOTIF_WIDTH) ? WSW'(MAX_MOTIF_WIDTH)
			: WSW'(motif_width);
		fb = '0;
		rb = '0;
		for (int i = 0; i < MAX_KMER; i++) begin
			if (i < 16) begin
				fb[2*i +: 2] = kmer_bases[(2*i)%32 +: 2];
			end
		end
		for (int i = 0; i < MAX_KMER; i++) begin
			j = int'(kn) - 1 - i;
			if (j >= 0) begin
				rb[2*i +: 2] = ~fb[2*j +: 2];
			end
		end
	end

	// width table: valid bits stand in for the reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_q <= '0;
		end else if (wr_m) begin
			wv_q[MW'(motif_index)] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		wvr_q <= wv_q[m_q];
	end

	kpbm_ram #(
		.WIDTH(WSW),
		.DEPTH(MAX_MOTIFS)
	) u_width_ram (
		.clk  (clk),
		.we   (wr_m),
		.waddr(MW'(motif_index)),
		.wdata(wsat),
		.raddr(m_q),
		.rdata(wrd)
	);

	assign wcur  = wvr_q ? wrd : '0;
	assign waddr = AW'(int'(motif_index) * MAX_MOTIF_WIDTH + int'(column));
	assign raddr = AW'(int'(m_q) * MAX_MOTIF_WIDTH + int'(c_q));

	// one weight store per base row, all four read on every column beat
	for (genvar r = 0; r < 4; r++) begin : g_row
		kpbm_ram #(
			.WIDTH(16),
			.DEPTH(WDEP)
		) u_wt_ram (
			.clk  (clk),
			.we   (wr_w && (int'(base_row) == r)),
			.waddr(waddr),
			.wdata(weight),
			.raddr(raddr),
			.rdata(wt[16*r +: 16])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_q       <= '0;
			c_q       <= '0;
			n_q       <= '0;
			k_q       <= '0;
			wlast_q   <= '0;
			ctl_s1    <= '0;
			motif_s1  <= '0;
			out_valid <= 1'b0;
		end else begin
			ctl_s1.vld  <= 1'b0;
			ctl_s1.col  <= 6'(c_q);
			ctl_s1.klen <= 6'(k_q);
			motif_s1    <= m_q;
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sc) begin
						k_q <= kn;
						n_q <= nn;
						m_q <= '0;
						state_q <= (nn == '0) ? S_DRAIN : S_WREQ;
					end
				end
				S_WREQ: state_q <= S_WCHK;
				S_WCHK: begin
					c_q <= '0;
					wlast_q <= CW'(wcur - WSW'(1));
					if (wcur == '0 || int'(wcur) < int'(k_q)) begin
						if (last_m) begin
							state_q <= S_DRAIN;
						end else begin
							m_q <= m_q + 1'b1;
							state_q <= S_WREQ;
						end
					end else begin
						state_q <= S_COLS;
					end
				end
				S_COLS: begin
					ctl_s1.vld <= 1'b1;
					if (c_q == wlast_q) begin
						if (last_m) begin
							state_q <= S_DRAIN;
						end else begin
							m_q <= m_q + 1'b1;
							state_q <= S_WREQ;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && sc) begin
			fwd_q <= fb;
			rev_q <= rb;
		end
		if (state_q == S_OUT && (!out_valid || !out_stall)) begin
			found      <= mfound;
			best_motif <= 6'(mmotif);
			best_score <= mscore;
		end
	end

	for (genvar l = 0; l < MAX_MOTIF_WIDTH; l++) begin : g_lane
		kpbm_lane #(
			.OFF     (l),
			.MAX_KMER(MAX_KMER)
		) u_fwd (
			.clk(clk),
			.ctl(ctl_s1),
			.seq(fwd_q),
			.wt (wt),
			.fin(fin_f[l]),
			.sum(sum_f[l])
		);
		kpbm_lane #(
			.OFF     (l),
			.MAX_KMER(MAX_KMER)
		) u_rev (
			.clk(clk),
			.ctl(ctl_s1),
			.seq(rev_q),
			.wt (wt),
			.fin(fin_r[l]),
			.sum(sum_r[l])
		);
	end

	assign mctl.vld   = ctl_s1.vld;
	assign mctl.motif = 10'(motif_s1);

	kpbm_merge #(
		.LANES(MAX_MOTIF_WIDTH)
	) u_merge (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (clear),
		.mctl  (mctl),
		.fin_f (fin_f),
		.sum_f (sum_f),
		.fin_r (fin_r),
		.sum_r (sum_r),
		.thr   (thr_q),
		.found (mfound),
		.motif (mmotif),
		.score (mscore)
	);
endmodule
`default_nettype wire
